/* design/sac_pkg.sv */
// ----------------------------------------------------------------------------
// sac_pkg
// Shared types and codes of the switching activity counter.
// ----------------------------------------------------------------------------
package sac_pkg;

   // Default number of traced bits.
   localparam int NUM_BITS_DEFAULT = 256;

   // Depth of the request queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Width of times and counters.
   localparam int TW = 64;

   localparam logic [TW-1:0] ALL_ONES = '1;

   // Bit value codes.
   localparam logic [1:0] VAL_ZERO = 2'd0;
   localparam logic [1:0] VAL_ONE  = 2'd1;
   localparam logic [1:0] VAL_UNK  = 2'd2;

   // Request function codes.
   localparam logic [2:0] FUNC_MARK   = 3'd0;
   localparam logic [2:0] FUNC_SET    = 3'd1;
   localparam logic [2:0] FUNC_OFF    = 3'd2;
   localparam logic [2:0] FUNC_ON     = 3'd3;
   localparam logic [2:0] FUNC_FINISH = 3'd4;
   localparam logic [2:0] FUNC_READ   = 3'd5;

   // Configuration register indexes.
   localparam logic [1:0] CSR_WINDOW_BEGIN = 2'd0;
   localparam logic [1:0] CSR_WINDOW_END   = 2'd1;
   localparam logic [1:0] CSR_AUTO_BEGIN   = 2'd2;

   // One classified request as it travels from front to back.
   typedef struct packed {
      logic [2:0]    func;
      logic [TW-1:0] time_value;
      logic [7:0]    bit_index;
      logic [1:0]    bit_value;
   } cmd_type;

   // Per-bit record held in the bit table.
   typedef struct packed {
      logic [1:0]    cval;
      logic [1:0]    pval;
      logic          pflag;
      logic [TW-1:0] since;
      logic [TW-1:0] t_zero;
      logic [TW-1:0] t_one;
      logic [TW-1:0] t_unk;
      logic [TW-1:0] toggles;
   } rec_type;

   // Record value after reset.
   localparam rec_type REC_RESET = '{
      cval: VAL_UNK, pval: VAL_ZERO, pflag: 1'b0, since: '0,
      t_zero: '0, t_one: '0, t_unk: '0, toggles: '0};

endpackage

/* design/sac_front.sv */
// ----------------------------------------------------------------------------
// sac_front
// Accepts requests, drops those without effect and queues the rest.
// ----------------------------------------------------------------------------
module sac_front #(
   parameter int NUM_BITS = sac_pkg::NUM_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [2:0]          req_func,
   input  logic [63:0]         req_time_value,
   input  logic [7:0]          req_bit_index,
   input  logic [1:0]          req_bit_value,
   input  logic                clearing,
   output logic                cmd_valid,
   output sac_pkg::cmd_type    cmd,
   input  logic                cmd_pop
);
   import sac_pkg::*;

   localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [16:0] NB = 17'(NUM_BITS);

   cmd_type          q_ff [QUEUE_DEPTH];
   logic [QAW-1:0]   wr_ptr_ff;
   logic [QAW-1:0]   rd_ptr_ff;
   logic [QCW-1:0]   count_ff;
   logic             accept;
   logic             keep;
   logic             do_pop;
   cmd_type          cls;

   // A request is taken when the queue has room and the table is ready.
   assign req_full = (count_ff == QCW'(QUEUE_DEPTH)) || clearing;
   assign accept   = req_push && !req_full;

   // Classify: unused codes and sets of untraced bits have no effect.
   always_comb begin
      cls.func       = req_func;
      cls.time_value = req_time_value;
      cls.bit_index  = req_bit_index;
      cls.bit_value  = (req_bit_value == 2'd3) ? VAL_UNK : req_bit_value;
      keep = (req_func <= FUNC_READ) &&
             !((req_func == FUNC_SET) && ({9'd0, req_bit_index} >= NB));
   end

   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign do_pop    = cmd_pop && cmd_valid;

   // Queue storage.
   always_ff @(posedge clock) begin
      if (accept && keep) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

   // Queue pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (accept && keep) begin
            wr_ptr_ff <= (wr_ptr_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if ((accept && keep) && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (!(accept && keep) && do_pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

/* design/sac_back.sv */
// ----------------------------------------------------------------------------
// sac_back
// Executes queued requests against the bit table and holds the result.
// ----------------------------------------------------------------------------
module sac_back #(
   parameter int NUM_BITS = sac_pkg::NUM_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [63:0]         csr_data,
   input  logic                cmd_valid,
   input  sac_pkg::cmd_type    cmd,
   output logic                cmd_pop,
   output logic                clearing,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [63:0]         rsp_zero_time,
   output logic [63:0]         rsp_one_time,
   output logic [63:0]         rsp_unknown_time,
   output logic [63:0]         rsp_toggle_total,
   output logic [63:0]         rsp_duration
);
   import sac_pkg::*;

   localparam int IW = (NUM_BITS > 1) ? $clog2(NUM_BITS) : 1;
   localparam int CW = $clog2(NUM_BITS + 1);
   localparam logic [CW-1:0] LAST = CW'(NUM_BITS - 1);
   localparam logic [16:0]   NB   = 17'(NUM_BITS);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_SETW  = 4'd2;
   localparam logic [3:0] S_RESP  = 4'd3;
   localparam logic [3:0] S_DIRTY = 4'd4;
   localparam logic [3:0] S_FETCH = 4'd5;
   localparam logic [3:0] S_CALC1 = 4'd6;
   localparam logic [3:0] S_CALC2 = 4'd7;
   localparam logic [3:0] S_WB    = 4'd8;
   localparam logic [3:0] S_POSTC = 4'd9;
   localparam logic [3:0] S_OBS1  = 4'd10;
   localparam logic [3:0] S_OBS2  = 4'd11;
   localparam logic [3:0] S_OBS3  = 4'd12;
   localparam logic [3:0] S_FINAL = 4'd13;

   localparam logic [1:0] MODE_COMMIT  = 2'd0;
   localparam logic [1:0] MODE_ACCOUNT = 2'd1;
   localparam logic [1:0] MODE_RESTART = 2'd2;

   // Bit table and dirty list.
   rec_type          mem [NUM_BITS];
   logic [IW-1:0]    dirty_mem [NUM_BITS];

   logic [3:0]       state_ff;
   cmd_type          cmd_ff;
   logic [1:0]       mode_ff;
   logic [CW-1:0]    cnt_ff;
   logic [CW-1:0]    dc_ff;
   logic [TW-1:0]    walk_t_ff, cur_ff, eb_ff, we_ff, os_ff, obs_ff, fin_dur_ff;
   logic [TW-1:0]    from_ff, span_ff, lo_ff, hi_ff, d_ff;
   logic             observing_ff, ss_ff, abp_ff, closed_ff, finished_ff;
   logic             tog_ff, chg_ff, gt_ff;
   rec_type          rec_ff;
   logic [IW-1:0]    dirty_rd_ff;
   logic             rsp_valid_ff;
   logic [TW-1:0]    rz_ff, ro_ff, ru_ff, rt_ff, rd_ff;

   logic             mem_we, mem_re, dirty_we, dirty_re;
   logic [IW-1:0]    mem_wa, mem_ra;
   rec_type          mem_wd;
   rec_type          upd;
   logic             idx_ok;
   logic             add_en;
   logic [TW-1:0]    stop_t;

   assign csr_ready = 1'b1;
   assign clearing  = (state_ff == S_CLEAR);
   assign idx_ok    = ({9'd0, cmd.bit_index} < NB);
   assign stop_t    = (we_ff == ALL_ONES) ? cur_ff : we_ff;

   // Record update for one walked or committed bit.
   always_comb begin
      upd    = rec_ff;
      add_en = gt_ff && ((mode_ff == MODE_ACCOUNT) || ((mode_ff == MODE_COMMIT) && chg_ff));
      if (add_en) begin
         if (rec_ff.cval == VAL_ZERO) begin
            upd.t_zero = rec_ff.t_zero + d_ff;
         end else if (rec_ff.cval == VAL_ONE) begin
            upd.t_one = rec_ff.t_one + d_ff;
         end else begin
            upd.t_unk = rec_ff.t_unk + d_ff;
         end
      end
      if ((mode_ff != MODE_COMMIT) || chg_ff) begin
         upd.since = walk_t_ff;
      end
      if (mode_ff == MODE_COMMIT) begin
         upd.pflag = 1'b0;
         if (chg_ff) begin
            upd.cval = rec_ff.pval;
            if (tog_ff) begin
               upd.toggles = rec_ff.toggles + 1'b1;
            end
         end
      end
   end

   // Memory port control.
   always_comb begin
      mem_we   = 1'b0;
      mem_wa   = cnt_ff[IW-1:0];
      mem_wd   = upd;
      mem_re   = 1'b0;
      mem_ra   = cnt_ff[IW-1:0];
      dirty_we = 1'b0;
      dirty_re = 1'b0;
      cmd_pop  = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wd = REC_RESET;
         end
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = !((cmd.func == FUNC_READ) && rsp_valid_ff);
               mem_ra  = IW'(cmd.bit_index);
               mem_re  = cmd_pop && idx_ok &&
                         ((cmd.func == FUNC_READ) ||
                          ((cmd.func == FUNC_SET) && !closed_ff && observing_ff));
            end
         end
         S_SETW: begin
            mem_we        = 1'b1;
            mem_wa        = IW'(cmd_ff.bit_index);
            mem_wd        = rec_ff;
            mem_wd.pval   = cmd_ff.bit_value;
            mem_wd.pflag  = 1'b1;
            dirty_we      = !rec_ff.pflag;
         end
         S_DIRTY: begin
            dirty_re = 1'b1;
         end
         S_FETCH: begin
            mem_re = 1'b1;
            mem_ra = (mode_ff == MODE_COMMIT) ? dirty_rd_ff : cnt_ff[IW-1:0];
         end
         S_WB: begin
            mem_we = 1'b1;
            mem_wa = (mode_ff == MODE_COMMIT) ? dirty_rd_ff : cnt_ff[IW-1:0];
         end
         default: begin
         end
      endcase
   end

   // Bit table and dirty list storage with registered reads.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rec_ff <= mem[mem_ra];
      end
      if (dirty_we) begin
         dirty_mem[dc_ff[IW-1:0]] <= IW'(cmd_ff.bit_index);
      end
      if (dirty_re) begin
         dirty_rd_ff <= dirty_mem[cnt_ff[IW-1:0]];
      end
   end

   // Datapath registers of the per-bit pipeline.
   always_ff @(posedge clock) begin
      if (state_ff == S_CALC1) begin
         lo_ff  <= (rec_ff.since < eb_ff) ? eb_ff : rec_ff.since;
         hi_ff  <= (walk_t_ff > we_ff) ? we_ff : walk_t_ff;
         chg_ff <= (rec_ff.pval != rec_ff.cval);
         tog_ff <= (cur_ff >= eb_ff) && (cur_ff < we_ff) &&
                   (rec_ff.cval != VAL_UNK) && (rec_ff.pval != VAL_UNK);
      end
      if (state_ff == S_CALC2) begin
         gt_ff <= (hi_ff > lo_ff);
         d_ff  <= hi_ff - lo_ff;
      end
      if (state_ff == S_OBS1) begin
         from_ff <= (os_ff > eb_ff) ? os_ff : eb_ff;
      end
      if (state_ff == S_OBS2) begin
         span_ff <= (walk_t_ff > from_ff) ? walk_t_ff - from_ff : '0;
      end
      if (cmd_pop) begin
         cmd_ff <= cmd;
      end
   end

   // Sequencer and global accounting state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         mode_ff      <= MODE_COMMIT;
         cnt_ff       <= '0;
         dc_ff        <= '0;
         walk_t_ff    <= '0;
         cur_ff       <= '0;
         eb_ff        <= '0;
         we_ff        <= ALL_ONES;
         os_ff        <= '0;
         obs_ff       <= '0;
         fin_dur_ff   <= '0;
         observing_ff <= 1'b1;
         ss_ff        <= 1'b0;
         abp_ff       <= 1'b0;
         closed_ff    <= 1'b0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_pop && rsp_valid_ff) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == LAST) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (cmd_valid && cmd_pop) begin
                  cnt_ff    <= '0;
                  walk_t_ff <= cur_ff;
                  case (cmd.func)
                     FUNC_READ: begin
                        if (idx_ok) begin
                           state_ff <= S_RESP;
                        end else begin
                           rz_ff        <= '0;
                           ro_ff        <= '0;
                           ru_ff        <= '0;
                           rt_ff        <= '0;
                           rd_ff        <= finished_ff ? fin_dur_ff : '0;
                           rsp_valid_ff <= 1'b1;
                        end
                     end
                     FUNC_SET: begin
                        if (!closed_ff && observing_ff) begin
                           state_ff <= S_SETW;
                        end
                     end
                     FUNC_MARK: begin
                        mode_ff <= MODE_COMMIT;
                        if (!closed_ff) begin
                           state_ff <= (dc_ff == '0) ? S_POSTC : S_DIRTY;
                        end
                     end
                     FUNC_OFF: begin
                        mode_ff <= MODE_COMMIT;
                        if (!closed_ff && observing_ff) begin
                           state_ff <= (dc_ff == '0) ? S_POSTC : S_DIRTY;
                        end
                     end
                     FUNC_FINISH: begin
                        mode_ff <= MODE_COMMIT;
                        if (!finished_ff) begin
                           state_ff <= (dc_ff == '0) ? S_POSTC : S_DIRTY;
                        end
                     end
                     FUNC_ON: begin
                        if (!closed_ff && !observing_ff) begin
                           observing_ff <= 1'b1;
                           os_ff        <= cur_ff;
                           mode_ff      <= MODE_RESTART;
                           state_ff     <= S_FETCH;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_SETW: begin
               if (!rec_ff.pflag) begin
                  dc_ff <= dc_ff + 1'b1;
               end
               state_ff <= S_IDLE;
            end
            S_RESP: begin
               rz_ff        <= rec_ff.t_zero;
               ro_ff        <= rec_ff.t_one;
               ru_ff        <= rec_ff.t_unk;
               rt_ff        <= rec_ff.toggles;
               rd_ff        <= finished_ff ? fin_dur_ff : '0;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            S_DIRTY: state_ff <= S_FETCH;
            S_FETCH: state_ff <= S_CALC1;
            S_CALC1: state_ff <= S_CALC2;
            S_CALC2: state_ff <= S_WB;
            S_WB: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (mode_ff == MODE_COMMIT) begin
                  state_ff <= ((cnt_ff + 1'b1) == dc_ff) ? S_POSTC : S_DIRTY;
               end else if (cnt_ff == LAST) begin
                  state_ff <= (mode_ff == MODE_RESTART) ? S_IDLE : S_OBS1;
               end else begin
                  state_ff <= S_FETCH;
               end
            end
            S_POSTC: begin
               // Pending values are committed; finish the request itself.
               dc_ff  <= '0;
               cnt_ff <= '0;
               case (cmd_ff.func)
                  FUNC_MARK: begin
                     cur_ff <= cmd_ff.time_value;
                     if (cmd_ff.time_value >= we_ff) begin
                        closed_ff <= 1'b1;
                     end
                     if (abp_ff) begin
                        eb_ff     <= cmd_ff.time_value;
                        os_ff     <= cmd_ff.time_value;
                        abp_ff    <= 1'b0;
                        walk_t_ff <= cmd_ff.time_value;
                        mode_ff   <= MODE_RESTART;
                        state_ff  <= S_FETCH;
                     end else begin
                        state_ff <= S_IDLE;
                     end
                  end
                  FUNC_OFF: begin
                     mode_ff  <= MODE_ACCOUNT;
                     state_ff <= S_FETCH;
                  end
                  default: begin
                     walk_t_ff <= stop_t;
                     mode_ff   <= MODE_ACCOUNT;
                     state_ff  <= observing_ff ? S_FETCH : S_FINAL;
                  end
               endcase
            end
            S_OBS1: state_ff <= S_OBS2;
            S_OBS2: state_ff <= S_OBS3;
            S_OBS3: begin
               obs_ff <= obs_ff + span_ff;
               if (cmd_ff.func == FUNC_OFF) begin
                  observing_ff <= 1'b0;
                  ss_ff        <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  state_ff <= S_FINAL;
               end
            end
            S_FINAL: begin
               fin_dur_ff  <= ss_ff ? obs_ff :
                              ((walk_t_ff > eb_ff) ? walk_t_ff - eb_ff : '0);
               finished_ff <= 1'b1;
               closed_ff   <= 1'b1;
               state_ff    <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase

         // The user must write configuration only while the block is idle; the block does not enforce this.
         if (csr_valid) begin
            case (csr_index)
               CSR_WINDOW_BEGIN: eb_ff  <= csr_data;
               CSR_WINDOW_END:   we_ff  <= csr_data;
               CSR_AUTO_BEGIN:   abp_ff <= csr_data[0];
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_empty        = !rsp_valid_ff;
   assign rsp_zero_time    = rz_ff;
   assign rsp_one_time     = ro_ff;
   assign rsp_unknown_time = ru_ff;
   assign rsp_toggle_total = rt_ff;
   assign rsp_duration     = rd_ff;

endmodule

/* design/switching_activity_counter.sv */
// ----------------------------------------------------------------------------
// switching_activity_counter
// Per-bit time at 0, 1 and unknown and toggle counts over a time window.
// ----------------------------------------------------------------------------
// After reset the bit table is cleared entry by entry, during which full stays
// high. A bit value request or a read keeps the engine busy while it writes
// the pending value or fetches the record. A time mark, dump-off or finish
// first commits every bit set since the last commit, stepping each through
// DIRTY, FETCH, CALC1, CALC2 and WB; dump-off and finish (while observing)
// then walk the whole table through FETCH, CALC1, CALC2 and WB and then the
// OBS states, and a dump-on or auto-begin time mark walks it through FETCH
// to WB alone. The bit table has a single read port. A two-entry request
// queue lets requests arrive while the engine works, and one result register
// holds the oldest result until it is popped.
module switching_activity_counter #(
   parameter int NUM_BITS = sac_pkg::NUM_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  logic [2:0]   req_func,
   input  logic [63:0]  req_time_value,
   input  logic [7:0]   req_bit_index,
   input  logic [1:0]   req_bit_value,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output logic [63:0]  rsp_zero_time,
   output logic [63:0]  rsp_one_time,
   output logic [63:0]  rsp_unknown_time,
   output logic [63:0]  rsp_toggle_total,
   output logic [63:0]  rsp_duration,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [63:0]  csr_data
);
   import sac_pkg::*;

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;
   logic    clearing;

   // Request intake and queue.
   sac_front #(.NUM_BITS(NUM_BITS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_func       (req_func),
      .req_time_value (req_time_value),
      .req_bit_index  (req_bit_index),
      .req_bit_value  (req_bit_value),
      .clearing       (clearing),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop)
   );

   // Accounting engine.
   sac_back #(.NUM_BITS(NUM_BITS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop),
      .clearing         (clearing),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_zero_time    (rsp_zero_time),
      .rsp_one_time     (rsp_one_time),
      .rsp_unknown_time (rsp_unknown_time),
      .rsp_toggle_total (rsp_toggle_total),
      .rsp_duration     (rsp_duration)
   );

endmodule

/* design/sac_checker.sv */
// ----------------------------------------------------------------------------
// sac_checker
// Port-level checks of the switching activity counter, bound to the top.
// ----------------------------------------------------------------------------
module sac_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_full,
   input logic         rsp_empty,
   input logic         rsp_pop,
   input logic [63:0]  rsp_zero_time,
   input logic [63:0]  rsp_duration
);

   // No result is shown right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result shown after reset");

   // Requests are held off while the bit table is cleared.
   a_reset_full: assert property (@(posedge clock) reset |=> req_full)
      else $error("request taken during table clear");

   // A single result register empties once its result is taken.
   a_pop_empties: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop) |=> rsp_empty)
      else $error("result register not emptied by pop");

   // A waiting result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> ($stable(rsp_zero_time) && $stable(rsp_duration)))
      else $error("waiting result changed");

endmodule

bind switching_activity_counter sac_checker u_sac_checker (
   .clock         (clock),
   .reset         (reset),
   .req_full      (req_full),
   .rsp_empty     (rsp_empty),
   .rsp_pop       (rsp_pop),
   .rsp_zero_time (rsp_zero_time),
   .rsp_duration  (rsp_duration)
);
